// ----- rtl/core/ypid_pkg.sv -----
// Shared constants for the yaw PID controller: register indexes, widths and angle limits.
package ypid_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [2:0] REG_DEAD_BAND   = 3'd3;
    localparam logic [2:0] REG_EDGE_MARGIN = 3'd4;
    localparam logic [2:0] REG_YAW_MODE    = 3'd5;

    // Port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 40;

    // Register reset values and the lowest accepted proportional gain
    localparam logic [12:0] PROP_GAIN_RST   = 13'd768;
    localparam logic [12:0] PROP_GAIN_MIN   = 13'd32;
    localparam logic [10:0] DEAD_BAND_RST   = 11'd10;
    localparam logic [9:0]  EDGE_MARGIN_RST = 10'd50;

    // Angle limits in tenths of a degree
    localparam logic signed [13:0] HALF_TURN    = 14'sd1800;
    localparam logic signed [13:0] FULL_TURN    = 14'sd3600;
    localparam logic signed [13:0] TWO_TURNS    = 14'sd7200;
    localparam logic signed [13:0] QUARTER_TURN = 14'sd900;

    // Derivative is skipped for steps at or below this
    localparam logic [15:0] DT_MIN_DERIV = 16'd66;

    // Integral and output limits
    localparam logic signed [40:0] INTEG_MAX = 41'sd549755813887;
    localparam logic signed [35:0] VEL_MAX   = 36'sd2147483647;

    // Divider length: 26 product bits and 32 scale bits
    localparam int DIV_BITS = 58;

endpackage

// ----- rtl/core/yaw_pid_with_unwind.sv -----
// Yaw PID controller with dead band, angle wrap, unwinding and a shared multiply/divide sequencer.
//
//  Channel | Direction | Handshake             | Payload
//  s_      | in        | s_tvalid / s_tready   | s_tdata: target, measured, travel, unwind, dt
//  m_      | out       | m_tvalid / m_tready   | m_tdata: velocity, unwinding_out
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// When the derivative runs, the restoring divider for the derivative term retires
// one quotient bit a cycle over 58 bits. With dt at or below 66 the divider is
// skipped, and in the dead band the multiplies are skipped and the velocity is zero.
// s_tready is high only while idle; a finished result holds in m_tdata until taken.
// Reset (aresetn low, synchronous) restores the registers and clears the integral
// and the previous error. cfg_ready is always high.
module yaw_pid_with_unwind (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [11:0] target_angle, [23:12] measured_angle, [25:24] travel_sign,
    // [26] unwinding_in, [42:27] step_time, [47:43] zero
    input  logic [ypid_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] velocity, [32] unwinding_out, [39:33] zero
    output logic [ypid_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ypid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ypid_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_DSET, S_DIV, S_ADDD, S_FIN, S_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [12:0]        prop_gain_reg;
    logic signed [13:0] integ_gain_reg;
    logic signed [13:0] deriv_gain_reg;
    logic [10:0]        dead_band_reg;
    logic [9:0]         edge_margin_reg;
    logic               yaw_mode_reg;

    // Controller state
    logic signed [39:0] integral_reg;
    logic signed [12:0] last_error_reg;

    // Captured input word
    logic signed [11:0] want_reg;
    logic signed [11:0] cur_reg;
    logic [1:0]         sgn_reg;
    logic               unw_in_reg;
    logic [15:0]        dt_reg;

    // Working registers
    logic signed [12:0] e_reg;
    logic               unw_reg;
    logic signed [34:0] prod_reg;
    logic signed [59:0] acc_reg;
    logic [ypid_pkg::DIV_BITS-1:0] nq_reg;
    logic [15:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic               dneg_reg;
    logic signed [31:0] vel_reg;

    // Error forming, wrap and unwind decision
    logic signed [12:0] want13, cur13, acur, seam_lim, quart_lim, e_raw;
    logic signed [13:0] e14, e_wrap, e_neg, e_pos, e_sel;
    logic               near_seam, want_mid, pos_trav, neg_trav, need, unw_sel;
    logic signed [12:0] e_new;
    logic [11:0]        e_abs;
    logic               in_band;

    always_comb begin
        want13    = {want_reg[11], want_reg};
        cur13     = {cur_reg[11], cur_reg};
        e_raw     = want13 - cur13;
        acur      = cur13[12] ? -cur13 : cur13;
        seam_lim  = 13'(ypid_pkg::HALF_TURN) - $signed({3'b000, edge_margin_reg});
        quart_lim = 13'(ypid_pkg::QUARTER_TURN) - $signed({3'b000, edge_margin_reg});
        near_seam = acur > seam_lim;
        want_mid  = (want13 >= -13'(ypid_pkg::QUARTER_TURN))
                 && (want13 <= 13'(ypid_pkg::QUARTER_TURN));
        pos_trav  = (sgn_reg == 2'b01);
        neg_trav  = sgn_reg[1];
        need      = want_mid && ((pos_trav && (near_seam || cur13 < -quart_lim))
                              || (neg_trav && (near_seam || cur13 > quart_lim)));
        e14       = {e_raw[12], e_raw};
        // Wrap into the half-turn range
        if (e14 < -ypid_pkg::HALF_TURN) begin
            e_wrap = e14 + ypid_pkg::FULL_TURN;
        end else if (e14 > ypid_pkg::HALF_TURN) begin
            e_wrap = e14 - ypid_pkg::FULL_TURN;
        end else begin
            e_wrap = e14;
        end
        // Force negative
        if (e14 < 0) begin
            e_neg = e14;
        end else if (e14 < ypid_pkg::FULL_TURN) begin
            e_neg = e14 - ypid_pkg::FULL_TURN;
        end else begin
            e_neg = e14 - ypid_pkg::TWO_TURNS;
        end
        // Force positive
        if (e14 > 0) begin
            e_pos = e14;
        end else if (e14 > -ypid_pkg::FULL_TURN) begin
            e_pos = e14 + ypid_pkg::FULL_TURN;
        end else begin
            e_pos = e14 + ypid_pkg::TWO_TURNS;
        end
        // Select by mode and unwind state
        if (!yaw_mode_reg) begin
            e_sel   = e14;
            unw_sel = unw_in_reg;
        end else if (!need && !unw_in_reg) begin
            e_sel   = e_wrap;
            unw_sel = 1'b0;
        end else begin
            unw_sel = 1'b1;
            if (pos_trav && need) begin
                e_sel = e_neg;
            end else if (neg_trav) begin
                e_sel = e_pos;
            end else begin
                e_sel = e14;
            end
        end
        e_new   = e_sel[12:0];
        e_abs   = e_new[12] ? 12'(-e_new) : e_new[11:0];
        in_band = e_abs < {1'b0, dead_band_reg};
    end

    // Shared multiplier operands
    logic signed [13:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [13:0] diff;
    logic signed [34:0] mul_p;

    always_comb begin
        diff = {e_reg[12], e_reg} - {last_error_reg[12], last_error_reg};
        case (state_reg)
            S_M0: begin
                mul_a = {e_reg[12], e_reg};
                mul_b = $signed({5'b0, dt_reg});
            end
            S_M2: begin
                mul_a = integ_gain_reg;
                mul_b = $signed({1'b0, integral_reg[19:0]});
            end
            S_M3: begin
                mul_a = integ_gain_reg;
                mul_b = {integral_reg[39], integral_reg[39:20]};
            end
            S_M4: begin
                mul_a = $signed({1'b0, prop_gain_reg});
                mul_b = {{8{e_reg[12]}}, e_reg};
            end
            S_M5: begin
                mul_a = deriv_gain_reg;
                mul_b = {{7{diff[13]}}, diff};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Integral update with saturation and sign clear
    logic signed [40:0] isum, isat;
    logic signed [39:0] inew;

    always_comb begin
        isum = {integral_reg[39], integral_reg} + {{6{prod_reg[34]}}, prod_reg};
        if (isum > ypid_pkg::INTEG_MAX) begin
            isat = ypid_pkg::INTEG_MAX;
        end else if (isum < -ypid_pkg::INTEG_MAX) begin
            isat = -ypid_pkg::INTEG_MAX;
        end else begin
            isat = isum;
        end
        if ((!e_reg[12] && e_reg != 0 && isat < 0) || (e_reg[12] && isat > 0)) begin
            inew = '0;
        end else begin
            inew = isat[39:0];
        end
    end

    // Divider step and derivative term
    logic [16:0]        trial;
    logic               qbit;
    logic [15:0]        rem_new;
    logic signed [34:0] pmag;
    logic signed [59:0] dval;
    logic signed [59:0] prod_ext;

    always_comb begin
        trial    = {rem_reg, nq_reg[ypid_pkg::DIV_BITS-1]};
        qbit     = trial >= {1'b0, dt_reg};
        rem_new  = qbit ? 16'(trial - {1'b0, dt_reg}) : trial[15:0];
        pmag     = prod_reg[34] ? -prod_reg : prod_reg;
        dval     = dneg_reg ? -$signed({2'b00, nq_reg}) : $signed({2'b00, nq_reg});
        prod_ext = {{25{prod_reg[34]}}, prod_reg};
    end

    // Scale down toward zero and saturate
    logic signed [59:0] acc_adj, acc_shr;
    logic signed [35:0] vq;
    logic signed [31:0] vsat;

    always_comb begin
        acc_adj = acc_reg + (acc_reg[59] ? 60'sd16777215 : 60'sd0);
        acc_shr = acc_adj >>> 24;
        vq      = acc_shr[35:0];
        if (vq > ypid_pkg::VEL_MAX) begin
            vsat = 32'(ypid_pkg::VEL_MAX);
        end else if (vq < -ypid_pkg::VEL_MAX) begin
            vsat = 32'(-ypid_pkg::VEL_MAX);
        end else begin
            vsat = vq[31:0];
        end
    end

    // Sequencer, configuration and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            prop_gain_reg   <= ypid_pkg::PROP_GAIN_RST;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            dead_band_reg   <= ypid_pkg::DEAD_BAND_RST;
            edge_margin_reg <= ypid_pkg::EDGE_MARGIN_RST;
            yaw_mode_reg    <= 1'b1;
            integral_reg    <= '0;
            last_error_reg  <= '0;
        end else begin
            // Register writes
            if (cfg_valid) begin
                case (cfg_index)
                    ypid_pkg::REG_PROP_GAIN: begin
                        if (cfg_data[12:0] >= ypid_pkg::PROP_GAIN_MIN) begin
                            prop_gain_reg <= cfg_data[12:0];
                        end
                    end
                    ypid_pkg::REG_INTEG_GAIN:  integ_gain_reg  <= $signed(cfg_data);
                    ypid_pkg::REG_DERIV_GAIN:  deriv_gain_reg  <= $signed(cfg_data);
                    ypid_pkg::REG_DEAD_BAND:   dead_band_reg   <= cfg_data[10:0];
                    ypid_pkg::REG_EDGE_MARGIN: edge_margin_reg <= cfg_data[9:0];
                    ypid_pkg::REG_YAW_MODE:    yaw_mode_reg    <= cfg_data[0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        want_reg   <= $signed(s_tdata[11:0]);
                        cur_reg    <= $signed(s_tdata[23:12]);
                        sgn_reg    <= s_tdata[25:24];
                        unw_in_reg <= s_tdata[26];
                        dt_reg     <= s_tdata[42:27];
                        state_reg  <= S_ERR;
                    end
                end
                S_ERR: begin
                    e_reg   <= e_new;
                    unw_reg <= unw_sel;
                    if (in_band) begin
                        vel_reg   <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_M0;
                    end
                end
                S_M0: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_M1;
                end
                S_M1: begin
                    integral_reg <= inew;
                    state_reg    <= S_M2;
                end
                S_M2: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_M3;
                end
                S_M3: begin
                    acc_reg   <= prod_ext;
                    prod_reg  <= mul_p;
                    state_reg <= S_M4;
                end
                S_M4: begin
                    acc_reg   <= acc_reg + (prod_ext <<< 20);
                    prod_reg  <= mul_p;
                    state_reg <= S_M5;
                end
                S_M5: begin
                    acc_reg  <= acc_reg + (prod_ext <<< 16);
                    prod_reg <= mul_p;
                    if (dt_reg > ypid_pkg::DT_MIN_DERIV) begin
                        state_reg <= S_DSET;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_DSET: begin
                    dneg_reg  <= prod_reg[34];
                    nq_reg    <= {pmag[25:0], 32'b0};
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg <= rem_new;
                    nq_reg  <= {nq_reg[ypid_pkg::DIV_BITS-2:0], qbit};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(ypid_pkg::DIV_BITS - 1)) begin
                        state_reg <= S_ADDD;
                    end
                end
                S_ADDD: begin
                    acc_reg   <= acc_reg + dval;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    vel_reg        <= vsat;
                    last_error_reg <= e_reg;
                    state_reg      <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Handshakes and result word
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {7'b0, unw_reg, vel_reg};
    assign cfg_ready = 1'b1;

endmodule
